[rtl/bpdf_pkg.sv]
// Shared constants, types and register codes for the byte-plane delta filter.
package bpdf_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int MAX_ELEMENTS = 1048576;

  // Index and count widths.
  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int EL_W     = $clog2(MAX_ELEMENTS);
  localparam int CNT_CH_W = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_EL_W = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W   = 28;
  localparam int BYTE_W   = 8;

  // Configuration port.
  localparam int CFG_DATA_W = CNT_EL_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = CFG_IDX_W'(1);
  localparam int                   CHAN_REG_W   = 9;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS = CFG_IDX_W'(2);

  localparam logic MODE_FILTER   = 1'b0;
  localparam logic MODE_UNFILTER = 1'b1;

  // Words held between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Settled configuration, already clamped to the legal ranges.
  typedef struct packed {
    logic                mode;
    logic [CH_W-1:0]     ch_last;
    logic [EL_W-1:0]     el_last;
    logic [CNT_EL_W-1:0] elems;
  } cfg_t;

  // One classified word on its way to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } item_t;

endpackage

[rtl/bpdf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bpdf_front.sv]
// Front end: accepts input words, tracks channel and element, forms addresses.
module bpdf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  bpdf_pkg::cfg_t         cfg,
  input  logic                   restart,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [bpdf_pkg::BYTE_W-1:0] data_byte,
  output logic                   push,
  output bpdf_pkg::item_t        item
);

  logic [bpdf_pkg::CH_W-1:0]   ch, ch_next;
  logic [bpdf_pkg::EL_W-1:0]   el, el_next;
  logic [bpdf_pkg::ADDR_W-1:0] addr, addr_next;
  logic                        ch_wrap;
  logic                        is_last;
  logic [bpdf_pkg::EL_W-1:0]   el_inc;

  assign push    = in_valid && in_ready;
  assign ch_wrap = (ch == cfg.ch_last);
  assign is_last = ch_wrap && (el == cfg.el_last);
  assign el_inc  = el + bpdf_pkg::EL_W'(1);

  // Word handed to the queue.
  always_comb begin
    item.data = data_byte;
    item.ch   = ch;
    item.addr = addr;
    item.last = is_last;
  end

  // Next position in the run. Planar addresses step by the element count
  // within an element and restart at the new element index on a wrap;
  // sequential addresses simply count.
  always_comb begin
    ch_next   = ch;
    el_next   = el;
    addr_next = addr;
    if (restart) begin
      ch_next   = '0;
      el_next   = '0;
      addr_next = '0;
    end else if (push) begin
      if (is_last) begin
        ch_next   = '0;
        el_next   = '0;
        addr_next = '0;
      end else if (ch_wrap) begin
        ch_next   = '0;
        el_next   = el_inc;
        addr_next = (cfg.mode == bpdf_pkg::MODE_UNFILTER) ?
                    addr + bpdf_pkg::ADDR_W'(1) : bpdf_pkg::ADDR_W'(el_inc);
      end else begin
        ch_next   = ch + bpdf_pkg::CH_W'(1);
        addr_next = (cfg.mode == bpdf_pkg::MODE_UNFILTER) ?
                    addr + bpdf_pkg::ADDR_W'(1) : addr + bpdf_pkg::ADDR_W'(cfg.elems);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch   <= '0;
      el   <= '0;
      addr <= '0;
    end else begin
      ch   <= ch_next;
      el   <= el_next;
      addr <= addr_next;
    end
  end

endmodule

[rtl/bpdf_queue.sv]
// Short FIFO that decouples the front end from the back end.
module bpdf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bpdf_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            head_valid,
  output bpdf_pkg::item_t head_item
);

  bpdf_pkg::item_t              slots [bpdf_pkg::QUEUE_DEPTH];
  logic [bpdf_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [bpdf_pkg::QCNT_W-1:0]  count;

  assign ready      = (count != bpdf_pkg::QCNT_W'(bpdf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  function automatic logic [bpdf_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bpdf_pkg::QPTR_W-1:0] p
  );
    ptr_inc = (p == bpdf_pkg::QPTR_W'(bpdf_pkg::QUEUE_DEPTH - 1)) ?
              '0 : p + bpdf_pkg::QPTR_W'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + bpdf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bpdf_pkg::QCNT_W'(1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/bpdf_back.sv]
// Back end: per-channel read-modify-write of the previous byte, and the output register.
module bpdf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bpdf_pkg::cfg_t              cfg,
  input  logic                        restart,
  input  logic                        head_valid,
  input  bpdf_pkg::item_t             head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpdf_pkg::BYTE_W-1:0] out_byte,
  output logic [bpdf_pkg::ADDR_W-1:0] out_address,
  output logic                        last
);

  logic                              b_valid;
  bpdf_pkg::item_t                   b_item;
  logic                              b_done;
  logic [bpdf_pkg::MAX_CHANNELS-1:0] valid_bits;
  logic [bpdf_pkg::BYTE_W-1:0]       rdata;
  logic [bpdf_pkg::CH_W-1:0]         fwd_ch;
  logic [bpdf_pkg::BYTE_W-1:0]       fwd_val;
  logic [bpdf_pkg::BYTE_W-1:0]       prev_raw, prev, result, store;

  assign b_done = b_valid && (!out_valid || out_ready);
  assign pop    = head_valid && (!b_valid || b_done);

  // Previous byte of each channel; the read is issued as a word enters the stage.
  bpdf_ram #(
    .WIDTH (bpdf_pkg::BYTE_W),
    .DEPTH (bpdf_pkg::MAX_CHANNELS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (b_done),
    .waddr (b_item.ch),
    .wdata (store),
    .re    (pop),
    .raddr (head_item.ch),
    .rdata (rdata)
  );

  // The RAM read misses a write made on the same edge, so the latest write
  // is held aside and used when it hits the same channel.
  always_comb begin
    prev_raw = (fwd_ch == b_item.ch) ? fwd_val : rdata;
    prev     = valid_bits[b_item.ch] ? prev_raw : '0;
    if (cfg.mode == bpdf_pkg::MODE_UNFILTER) begin
      result = b_item.data + prev;
      store  = result;
    end else begin
      result = b_item.data - prev;
      store  = b_item.data;
    end
  end

  // Control state: stage and output occupancy, per-channel valid marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        valid_bits <= '0;
      end else if (b_done) begin
        if (b_item.last) begin
          valid_bits <= '0;
        end else begin
          valid_bits[b_item.ch] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= head_item;
    end
    if (b_done) begin
      fwd_ch      <= b_item.ch;
      fwd_val     <= store;
      out_byte    <= result;
      out_address <= b_item.addr;
      last        <= b_item.last;
    end
  end

endmodule

[rtl/byte_plane_delta_filter.sv]
// Top level of the byte-plane delta filter: configuration registers and wiring.
//
// Input words are bytes in element-major order (channel fastest) on
// in_valid/in_ready with data_byte. Each accepted word yields one output word
// on out_valid/out_ready carrying out_byte, out_address and last. In filter
// mode out_byte is the byte minus the channel's previous byte and the address
// is planar (channel * elements + element); in unfilter mode it is the delta
// plus the channel's previous result at the sequential address. last marks
// the final byte of a run, after which every channel starts again from zero.
//
// Throughput is one word per clock while the receiver keeps out_ready high.
// An accepted word passes through the queue and the previous-byte RAM read
// stage, which has a registered read, before it is offered on the output.
// When the receiver stalls, in_ready stays high until the two-entry queue,
// the RAM stage and the output register hold four words.
// Reset empties the pipeline and loads mode filter, one channel and one
// element. Any write to registers 0 to 2 restarts the run; the user must
// make writes only while the block is idle; the block does not enforce it.
module byte_plane_delta_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpdf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bpdf_pkg::BYTE_W-1:0]     data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpdf_pkg::BYTE_W-1:0]     out_byte,
  output logic [bpdf_pkg::ADDR_W-1:0]     out_address,
  output logic                            last
);

  bpdf_pkg::cfg_t                       cfg;
  logic                                 restart;
  logic [bpdf_pkg::CHAN_REG_W-1:0]      ch_raw;
  logic [bpdf_pkg::CNT_EL_W-1:0]        el_raw, elems_w;
  logic [bpdf_pkg::CH_W-1:0]            ch_last_w;
  logic                                 push, pop, head_valid;
  bpdf_pkg::item_t                      push_item, head_item;

  assign restart = cfg_we && (cfg_index == bpdf_pkg::REG_MODE ||
                              cfg_index == bpdf_pkg::REG_CHANNELS ||
                              cfg_index == bpdf_pkg::REG_ELEMENTS);
  assign ch_raw  = cfg_data[bpdf_pkg::CHAN_REG_W-1:0];
  assign el_raw  = cfg_data[bpdf_pkg::CNT_EL_W-1:0];

  // Clamp counts to their legal ranges as they are written.
  always_comb begin
    if (ch_raw == '0) begin
      ch_last_w = '0;
    end else if (ch_raw > bpdf_pkg::CHAN_REG_W'(bpdf_pkg::MAX_CHANNELS)) begin
      ch_last_w = bpdf_pkg::CH_W'(bpdf_pkg::MAX_CHANNELS - 1);
    end else begin
      ch_last_w = bpdf_pkg::CH_W'(ch_raw - bpdf_pkg::CHAN_REG_W'(1));
    end
    if (el_raw == '0) begin
      elems_w = bpdf_pkg::CNT_EL_W'(1);
    end else if (el_raw > bpdf_pkg::CNT_EL_W'(bpdf_pkg::MAX_ELEMENTS)) begin
      elems_w = bpdf_pkg::CNT_EL_W'(bpdf_pkg::MAX_ELEMENTS);
    end else begin
      elems_w = el_raw;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= bpdf_pkg::MODE_FILTER;
      cfg.ch_last <= '0;
      cfg.el_last <= '0;
      cfg.elems   <= bpdf_pkg::CNT_EL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpdf_pkg::REG_MODE: begin
          cfg.mode <= cfg_data[0];
        end
        bpdf_pkg::REG_CHANNELS: begin
          cfg.ch_last <= ch_last_w;
        end
        bpdf_pkg::REG_ELEMENTS: begin
          cfg.elems   <= elems_w;
          cfg.el_last <= bpdf_pkg::EL_W'(elems_w - bpdf_pkg::CNT_EL_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  bpdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .push      (push),
    .item      (push_item)
  );

  bpdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .ready      (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  bpdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_address (out_address),
    .last        (last)
  );

endmodule

[rtl/bpdf_checker.sv]
// Port-level checks for the byte-plane delta filter, bound to the top level.
module bpdf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bpdf_pkg::BYTE_W-1:0] out_byte,
  input logic [bpdf_pkg::ADDR_W-1:0] out_address,
  input logic                        last
);

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_address) && $stable(last))
    else $error("output word changed while stalled");

  // Reset leaves the pipeline empty and ready for input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // The input side only backs up behind a word waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

  // The first word after reset needs the queue and the RAM stage before it
  // can reach the output, so the output stays empty right after reset.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("output appeared too early");

endmodule

bind byte_plane_delta_filter bpdf_checker u_bpdf_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the byte-plane delta filter, with its own model of the run state.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [bpdf_pkg::CFG_IDX_W-1:0] REG_UNUSED = bpdf_pkg::CFG_IDX_W'(3);

  // One expected output word.
  typedef struct packed {
    logic [bpdf_pkg::BYTE_W-1:0] value;
    logic [bpdf_pkg::ADDR_W-1:0] addr;
    logic                        final_flag;
  } coded_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [bpdf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bpdf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [bpdf_pkg::BYTE_W-1:0]     data_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [bpdf_pkg::BYTE_W-1:0]     out_byte;
  logic [bpdf_pkg::ADDR_W-1:0]     out_address;
  logic                            last;

  // Model copy of the registers and the per-channel run state.
  logic                            cur_mode;
  logic [bpdf_pkg::CHAN_REG_W-1:0] cur_channels;
  logic [bpdf_pkg::CFG_DATA_W-1:0] cur_elements;
  logic [bpdf_pkg::BYTE_W-1:0]     seen_byte [bpdf_pkg::MAX_CHANNELS];
  logic                            seen_valid [bpdf_pkg::MAX_CHANNELS];
  int unsigned                     chan_pos;
  int unsigned                     elem_pos;

  coded_word_t pending_words[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  byte_plane_delta_filter u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_address(out_address),
    .last       (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // A count of zero acts as one, and counts above the maximum saturate.
  function automatic int unsigned clamp_count(input int unsigned count, input int unsigned top);
    if (count == 0) return 1;
    if (count > top) return top;
    return count;
  endfunction

  function automatic void restart_run();
    foreach (seen_valid[i]) seen_valid[i] = 1'b0;
    chan_pos = 0;
    elem_pos = 0;
  endfunction

  // Any write to a known register restarts the run; the unused index does nothing.
  function automatic void apply_register(input logic [bpdf_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [bpdf_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      bpdf_pkg::REG_MODE: begin
        cur_mode = value[0];
      end
      bpdf_pkg::REG_CHANNELS: begin
        cur_channels = value[bpdf_pkg::CHAN_REG_W-1:0];
      end
      bpdf_pkg::REG_ELEMENTS: begin
        cur_elements = value;
      end
      default: begin
        return;
      end
    endcase
    restart_run();
  endfunction

  // Work out the output word for one accepted byte and advance the run position.
  function automatic coded_word_t code_byte(input logic [bpdf_pkg::BYTE_W-1:0] d);
    int unsigned                 chans;
    int unsigned                 elems;
    int unsigned                 ch;
    int unsigned                 el;
    logic [bpdf_pkg::BYTE_W-1:0] prior;
    longint unsigned             addr_full;
    coded_word_t                 w;
    chans = clamp_count(cur_channels, bpdf_pkg::MAX_CHANNELS);
    elems = clamp_count(cur_elements, bpdf_pkg::MAX_ELEMENTS);
    ch = chan_pos;
    el = elem_pos;
    if (ch >= chans) ch = 0;
    if (el >= elems) el = 0;
    prior = seen_valid[ch] ? seen_byte[ch] : '0;
    if (cur_mode == bpdf_pkg::MODE_FILTER) begin
      w.value = d - prior;
      seen_byte[ch] = d;
      addr_full = longint'(ch) * elems + el;
    end else begin
      w.value = d + prior;
      seen_byte[ch] = w.value;
      addr_full = longint'(el) * chans + ch;
    end
    seen_valid[ch] = 1'b1;
    w.addr = addr_full[bpdf_pkg::ADDR_W-1:0];
    w.final_flag = (ch == chans - 1) && (el == elems - 1);
    if (w.final_flag) begin
      restart_run();
    end else begin
      ch++;
      if (ch >= chans) begin
        ch = 0;
        el++;
      end
      chan_pos = ch;
      elem_pos = el;
    end
    return w;
  endfunction

  // Track register writes and accepted bytes, and compare each output word in order.
  always @(posedge clk) begin : scoreboard
    coded_word_t want;
    if (rst) begin
      cur_mode = bpdf_pkg::MODE_FILTER;
      cur_channels = bpdf_pkg::CHAN_REG_W'(1);
      cur_elements = bpdf_pkg::CFG_DATA_W'(1);
      restart_run();
      pending_words.delete();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) pending_words.push_back(code_byte(data_byte));
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected word: byte %02h address %07h last %0b",
                     out_byte, out_address, last);
        end else begin
          want = pending_words.pop_front();
          if (out_byte !== want.value || out_address !== want.addr ||
              last !== want.final_flag) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"mismatch: byte %02h/%02h address %07h/%07h last %0b/%0b",
                        " (expected/actual)"},
                       want.value, out_byte, want.addr, out_address,
                       want.final_flag, last);
          end
        end
      end
    end
  end

  // Output stalls, drawn fresh on every cycle.
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one byte after an optional random gap and hold it until it is taken.
  task automatic send_word(input logic [bpdf_pkg::BYTE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Stop sending and wait until every expected word has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [bpdf_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bpdf_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_run(input logic mode_bit, input int unsigned chans,
                         input int unsigned elems);
    write_register(bpdf_pkg::REG_MODE, {31'd0, mode_bit});
    write_register(bpdf_pkg::REG_CHANNELS, chans);
    write_register(bpdf_pkg::REG_ELEMENTS, elems);
  endtask

  // Reset leaves one channel and one element, so every byte is a run of its own.
  task automatic test_reset_defaults();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h5A);
    send_word(8'hA5);
  endtask

  // Back-to-back bytes on a single channel hit the same previous byte every cycle.
  task automatic test_single_channel_forwarding();
    int saved_send;
    int saved_recv;
    saved_send = send_idle_pct;
    saved_recv = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_run(bpdf_pkg::MODE_FILTER, 1, 4);
    send_word(8'h10);
    send_word(8'h0F);
    send_word(8'hFF);
    send_word(8'h00);
    set_run(bpdf_pkg::MODE_UNFILTER, 1, 4);
    send_word(8'h80);
    send_word(8'h80);
    send_word(8'h01);
    send_word(8'hFF);
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  // Zero counts act as one, and oversized counts saturate at the maximum.
  task automatic test_count_clamping();
    set_run(bpdf_pkg::MODE_FILTER, 0, 0);
    send_word(8'h33);
    send_word(8'hCC);
    set_run(bpdf_pkg::MODE_UNFILTER, 511, 2097151);
    send_word(8'h01);
    send_word(8'hFE);
    send_word(8'h7F);
    set_run(bpdf_pkg::MODE_FILTER, 256, 1048576);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'h80);
  endtask

  // A write to the unused index must leave the run where it is.
  task automatic test_ignored_register();
    set_run(bpdf_pkg::MODE_UNFILTER, 2, 3);
    send_word(8'h11);
    send_word(8'h22);
    send_word(8'hF0);
    write_register(REG_UNUSED, (1 << bpdf_pkg::CFG_DATA_W) - 1);
    send_word(8'h0F);
    send_word(8'h44);
    send_word(8'h9C);
    send_word(8'h01);
    send_word(8'h02);
  endtask

  // Random settings, mostly whole runs, with some runs cut short by the next setting.
  task automatic test_random_runs(input int unsigned budget);
    int unsigned sent;
    int unsigned chans;
    int unsigned elems;
    int unsigned run_len;
    int unsigned burst;
    int          pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) chans = $urandom_range(1, 8);
      else if (pick < 78) chans = $urandom_range(9, 40);
      else if (pick < 86) chans = 256;
      else if (pick < 90) chans = 0;
      else if (pick < 95) chans = $urandom_range(257, 511);
      else chans = 1;
      pick = $urandom_range(99);
      if (clamp_count(chans, bpdf_pkg::MAX_CHANNELS) > 40) elems = $urandom_range(0, 1);
      else if (pick < 75) elems = $urandom_range(1, 12);
      else if (pick < 85) elems = $urandom_range(13, 64);
      else if (pick < 89) elems = 0;
      else if (pick < 93) elems = bpdf_pkg::MAX_ELEMENTS;
      else if (pick < 96) elems = $urandom_range(bpdf_pkg::MAX_ELEMENTS + 1,
                                                 (1 << bpdf_pkg::CFG_DATA_W) - 1);
      else elems = $urandom_range(1, bpdf_pkg::MAX_ELEMENTS);
      set_run(1'($urandom_range(1)), chans, elems);
      if ($urandom_range(9) == 0)
        write_register(REG_UNUSED, $urandom_range((1 << bpdf_pkg::CFG_DATA_W) - 1));
      run_len = clamp_count(chans, bpdf_pkg::MAX_CHANNELS) *
                clamp_count(elems, bpdf_pkg::MAX_ELEMENTS);
      if (run_len <= 300) begin
        burst = run_len * $urandom_range(1, 3);
        if ($urandom_range(99) < 15) burst = $urandom_range(1, burst);
      end else begin
        burst = $urandom_range(20, 150);
      end
      if (burst > budget - sent) burst = budget - sent;
      repeat (burst) send_word(bpdf_pkg::BYTE_W'($urandom_range(255)));
      sent += burst;
    end
  endtask

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_single_channel_forwarding();
    test_count_clamping();
    test_ignored_register();
    test_random_runs(640);
    send_idle_pct = 58;
    recv_idle_pct = 14;
    test_random_runs(640);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_runs(640);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
